[hw/rtl/pal_pkg.sv]
// ---------------------------------------------------------------------------
// Positional array list package
// Shared widths, request and status codes, controller states and the
// control bundle that the list controller broadcasts to every storage cell.
// ---------------------------------------------------------------------------
package pal_pkg;

   // Fixed field widths of the request and response channels.
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Request kinds.
   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_DUMP   = 2'd3
   } action_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_FULL   = 2'd1,
      STS_EMPTY  = 2'd2,
      STS_BADPOS = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

   // Operation applied by every cell of the chain together.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL,
      CELL_ROT
   } cell_op_type;

   // Control bundle broadcast to the cell chain.
   typedef struct packed {
      cell_op_type             op;
      logic [POS_W-1:0]        pos;
      logic [POS_W-1:0]        count;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

[hw/rtl/positional_array_list_unit.sv]
// ---------------------------------------------------------------------------
// Positional array list unit
// Ordered list of signed 32-bit entries kept in a chain of shifting cells.
// ---------------------------------------------------------------------------
// Each request is taken in the idle state and carried out from the execute
// state, and a new request is taken only once the last has finished. Every
// cell decides on its own whether to keep its entry or take its neighbor's,
// so an insert or delete moves the whole tail at once. A dump rotates the
// stored entries through cell zero, one entry per cycle while the output
// register is free, and the list is back in order when it ends. A response
// waits in an output register, and the next request is taken while it waits;
// execution stalls only until that register frees. Reset clears the control
// registers only, not the cells; no clearing pass is needed.
module positional_array_list_unit
   import pal_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // position[6:0], value[38:7], zero pad
   input  logic [1:0]  req_tuser,    // action[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // data[31:0], entry_count[38:32], zero pad
   output logic [1:0]  rsp_tuser,    // status[1:0]
   output logic        rsp_tlast
);

   localparam int               CNT_W   = $clog2(DEPTH + 1);
   localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

   // Controller registers.
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   action_type               action_ff, action_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] value_ff, value_in;

   // Response registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Chain signals.
   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic signed [DATA_W-1:0] picked;
   logic [POS_W-1:0]         count_w;
   logic                     slot_free;

   assign count_w   = POS_W'(count_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Cell chain.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_v;
      logic signed [DATA_W-1:0] next_v;
      if (i == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_prev
         assign prev_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_v = '0;
      end else begin : g_next
         assign next_v = cell_value[i+1];
      end
      pal_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .prev_value (prev_v),
         .next_value (next_v),
         .head_value (cell_value[0]),
         .value      (cell_value[i])
      );
   end

   // Collect the entry at the delete position; at most one cell is selected.
   always_comb begin
      picked = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (POS_W'(i) == pos_ff) begin
            picked = cell_value[i];
         end
      end
   end

   // Next state, chain control and response loading.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      action_in     = action_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.pos      = pos_ff;
      ctrl.count    = count_w;
      ctrl.value    = value_ff;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               action_in = action_type'(req_tuser);
               pos_in    = req_tdata[POS_W-1:0];
               value_in  = req_tdata[POS_W+DATA_W-1:POS_W];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (action_ff == ACT_DUMP && count_ff != '0) begin
               // Hand over to the rotation loop.
               remain_in = count_ff;
               state_in  = ST_DUMP;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STS_OK;
               state_in      = ST_IDLE;
               case (action_ff)
                  ACT_APPEND: begin
                     if (count_w == DEPTH_P) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        ctrl.op  = CELL_INS;
                        ctrl.pos = count_w;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_INSERT: begin
                     if (count_w == DEPTH_P) begin
                        rsp_status_in = STS_FULL;
                     end else if (pos_ff > count_w) begin
                        rsp_status_in = STS_BADPOS;
                     end else begin
                        ctrl.op  = CELL_INS;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else if (pos_ff >= count_w) begin
                        rsp_status_in = STS_BADPOS;
                     end else begin
                        ctrl.op     = CELL_DEL;
                        rsp_data_in = picked;
                        count_in    = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     // Dump of an empty list.
                     rsp_status_in = STS_EMPTY;
                  end
               endcase
               rsp_count_in = POS_W'(count_in);
            end
         end
         ST_DUMP: begin
            // Emit the head entry and rotate the list by one.
            if (slot_free) begin
               ctrl.op       = CELL_ROT;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_data_in   = cell_value[0];
               rsp_count_in  = count_w;
               rsp_last_in   = (remain_ff == CNT_W'(1));
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hw/rtl/pal_cell.sv]
// ---------------------------------------------------------------------------
// Positional array list storage cell
// Holds one list entry and moves it to or from its neighbors on insert,
// delete and dump rotation, based on its own index.
// ---------------------------------------------------------------------------
module pal_cell
   import pal_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] prev_value,   // entry of the cell below
   input  logic signed [DATA_W-1:0] next_value,   // entry of the cell above
   input  logic signed [DATA_W-1:0] head_value,   // entry of cell zero
   output logic signed [DATA_W-1:0] value
);

   localparam logic [POS_W-1:0] IDX      = POS_W'(INDEX);
   localparam logic [POS_W-1:0] IDX_NEXT = POS_W'(INDEX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // Select the new entry for this position.
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INS: begin
            if (IDX == ctrl.pos) begin
               value_in = ctrl.value;
            end else if ((IDX > ctrl.pos) && (IDX <= ctrl.count)) begin
               value_in = prev_value;
            end
         end
         CELL_DEL: begin
            if ((IDX >= ctrl.pos) && (IDX_NEXT < ctrl.count)) begin
               value_in = next_value;
            end
         end
         CELL_ROT: begin
            if (IDX_NEXT < ctrl.count) begin
               value_in = next_value;
            end else if (IDX_NEXT == ctrl.count) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Entry storage; no reset, the list count guards every read.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
